// ===== design/icu_pkg.sv =====
`timescale 1ns / 1ps
package icu_pkg;

  localparam int ValueWidth = 32;
  localparam int CofWidth   = 33;
  localparam int ProdWidth  = 64;
  localparam int RndWidth   = 48;
  localparam int NumWidth   = 48;
  localparam int EpsWidth   = 16;
  localparam logic [EpsWidth-1:0] EpsReset = 16'd1;
  localparam logic [3:0] TriggerIndex = 4'd15;

  typedef enum logic [4:0] {
    S_IDLE, S_RA, S_RB, S_RC, S_RD, S_RT, S_M2, S_M2D, S_MT, S_ACC, S_CW,
    S_DA, S_DL, S_DM, S_DACC, S_CHK, S_SOUT, S_QA, S_QL, S_QDIV, S_QOUT
  } icu_state_t;

  function automatic logic signed [RndWidth-1:0] rnd16(input logic signed [ProdWidth-1:0] p);
    logic signed [ProdWidth-1:0] t;
    t = p + 64'sd32768;
    return t[ProdWidth-1:16];
  endfunction

  function automatic logic signed [ValueWidth-1:0] sat32(input logic signed [ProdWidth-1:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[ValueWidth-1:0];
  endfunction

  function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] ex);
    return (k < ex) ? k : 2'(k + 2'd1);
  endfunction

endpackage

// ===== design/icu_divider.sv =====
`timescale 1ns / 1ps
module icu_divider
  import icu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NumWidth-1:0] num,
  input  logic [63:0]         den,
  output logic                done,
  output logic [NumWidth-1:0] quo
);

  logic [63:0]         rem;
  logic [63:0]         den_q;
  logic [NumWidth-1:0] nq;
  logic [5:0]          cnt;
  logic                busy;
  logic [64:0]         trial;
  logic [64:0]         diff;
  logic                ge;

  assign trial = {rem, nq[NumWidth-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};
  assign quo   = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        nq    <= num;
        den_q <= den;
      end else if (busy) begin
        rem <= ge ? diff[63:0] : trial[63:0];
        nq  <= {nq[NumWidth-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(NumWidth - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/matrix4_inverse_cofactor_unit.sv =====
`timescale 1ns / 1ps
// Entries are taken one beat per cycle while idle; entry 15 starts the inversion.
// The cofactor pass runs on the single store read port, then the determinant is summed,
// and each inverse entry is then divided in the bit-serial divider.
// A singular matrix skips the division and gives a single result flagged singular.
// Reset clears control state and sets the epsilon register to EpsDefault; store undefined.
module matrix4_inverse_cofactor_unit
  import icu_pkg::*;
#(
  parameter logic [EpsWidth-1:0] EpsDefault = EpsReset
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ValueWidth-1:0] entry_value,
  input  logic [3:0]                   entry_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ValueWidth-1:0] inverse_value,
  output logic [3:0]                   out_index,
  output logic                         singular,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [EpsWidth-1:0]          cfg_data
);

  icu_state_t state, state_next;

  logic [ValueWidth-1:0]      store_mem [16];
  logic [CofWidth-1:0]        cof_mem [16];
  logic signed [ValueWidth-1:0] store_rdata;
  logic signed [CofWidth-1:0] cof_rdata;
  logic [3:0]                 store_raddr, store_waddr, cof_raddr;
  logic                       store_we, cof_we;
  logic [ValueWidth-1:0]      store_wdata;
  logic signed [CofWidth-1:0] cof_wdata;

  logic [EpsWidth-1:0]        zero_epsilon;
  logic [3:0]                 ci, dk;
  logic [1:0]                 term;
  logic signed [CofWidth-1:0] x, y;
  logic signed [ProdWidth-1:0] prod, det;
  logic signed [RndWidth-1:0] p1;
  logic signed [49:0]         acc;
  logic                       qneg;
  logic signed [65:0]         mult;
  logic signed [RndWidth-1:0] rp;
  logic signed [ValueWidth-1:0] acc_sat;
  logic [63:0]                det_mag;
  logic [CofWidth-1:0]        cof_mag;
  logic                       in_accept, out_free, out_load, is_sing;
  logic                       div_start, div_done;
  logic [NumWidth-1:0]        div_quo;
  logic [1:0]                 ri, cj, ca, cb;
  logic signed [ValueWidth-1:0] q_sat, load_value;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign mult      = x * y;
  assign rp        = rnd16(prod);
  assign acc_sat   = sat32(64'(acc));
  assign det_mag   = det[63] ? 64'(-det) : det;
  assign is_sing   = det_mag <= {48'd0, zero_epsilon};
  assign cof_mag   = cof_rdata[CofWidth-1] ? CofWidth'(-cof_rdata) : cof_rdata;
  assign ri        = ci[3:2];
  assign cj        = ci[1:0];
  assign ca        = (term == 2'd0) ? 2'd1 : 2'd0;
  assign cb        = (term == 2'd2) ? 2'd1 : 2'd2;

  always_comb begin
    if (!qneg) begin
      q_sat = (div_quo > 48'd2147483647) ? 32'sh7fffffff : div_quo[31:0];
    end else begin
      q_sat = (div_quo > 48'd2147483648) ? 32'sh80000000 : -div_quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    store_rdata <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (cof_we) begin
      cof_mem[ci] <= cof_wdata;
    end
    cof_rdata <= cof_mem[cof_raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_accept && entry_index == TriggerIndex) state_next = S_RA;
      S_RA:   state_next = S_RB;
      S_RB:   state_next = S_RC;
      S_RC:   state_next = S_RD;
      S_RD:   state_next = S_RT;
      S_RT:   state_next = S_M2;
      S_M2:   state_next = S_M2D;
      S_M2D:  state_next = S_MT;
      S_MT:   state_next = S_ACC;
      S_ACC:  state_next = (term == 2'd2) ? S_CW : S_RA;
      S_CW:   state_next = (ci == 4'd15) ? S_DA : S_RA;
      S_DA:   state_next = S_DL;
      S_DL:   state_next = S_DM;
      S_DM:   state_next = S_DACC;
      S_DACC: state_next = (dk == 4'd3) ? S_CHK : S_DA;
      S_CHK:  state_next = is_sing ? S_SOUT : S_QA;
      S_SOUT: if (out_free) state_next = S_IDLE;
      S_QA:   state_next = S_QL;
      S_QL:   state_next = S_QDIV;
      S_QDIV: if (div_done) state_next = S_QOUT;
      S_QOUT: if (out_free) state_next = (dk == 4'd15) ? S_IDLE : S_QA;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    store_we    = 1'b0;
    store_waddr = entry_index;
    store_wdata = entry_value;
    store_raddr = '0;
    cof_raddr   = '0;
    cof_we      = 1'b0;
    cof_wdata   = (ci[2] ^ ci[0]) ? -CofWidth'(acc_sat) : CofWidth'(acc_sat);
    div_start   = 1'b0;
    out_load    = 1'b0;
    load_value  = '0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        store_we = in_valid;
      end
      S_RA:   store_raddr = {skip_idx(2'd1, ri), skip_idx(ca, cj)};
      S_RB:   store_raddr = {skip_idx(2'd2, ri), skip_idx(cb, cj)};
      S_RC:   store_raddr = {skip_idx(2'd2, ri), skip_idx(ca, cj)};
      S_RD:   store_raddr = {skip_idx(2'd1, ri), skip_idx(cb, cj)};
      S_RT:   store_raddr = {skip_idx(2'd0, ri), skip_idx(term, cj)};
      S_CW:   cof_we = 1'b1;
      S_DA: begin
        store_raddr = {2'd0, dk[1:0]};
        cof_raddr   = dk;
      end
      S_SOUT: out_load = out_free;
      S_QA:   cof_raddr = {dk[1:0], dk[3:2]};
      S_QL:   div_start = 1'b1;
      S_QOUT: begin
        out_load   = out_free;
        load_value = q_sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      zero_epsilon <= EpsDefault;
      det          <= '0;
      ci           <= '0;
      dk           <= '0;
      term         <= '0;
      acc          <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        zero_epsilon <= cfg_data;
      end
      if (out_load) begin
        out_valid     <= 1'b1;
        inverse_value <= load_value;
        out_index     <= (state == S_QOUT) ? dk : 4'd0;
        singular      <= (state == S_SOUT);
        last          <= (state == S_SOUT) || (dk == 4'd15);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          ci   <= '0;
          dk   <= '0;
          term <= '0;
          acc  <= '0;
        end
        S_RB:  x <= CofWidth'(store_rdata);
        S_RC:  y <= CofWidth'(store_rdata);
        S_RD: begin
          prod <= mult[63:0];
          x    <= CofWidth'(store_rdata);
        end
        S_RT: begin
          y  <= CofWidth'(store_rdata);
          p1 <= rp;
        end
        S_M2: begin
          prod <= mult[63:0];
          x    <= CofWidth'(store_rdata);
        end
        S_M2D: y <= CofWidth'(sat32(64'(p1) - 64'(rp)));
        S_MT:  prod <= mult[63:0];
        S_ACC: begin
          acc  <= term[0] ? acc - 50'(rp) : acc + 50'(rp);
          term <= (term == 2'd2) ? 2'd0 : 2'(term + 2'd1);
        end
        S_CW: begin
          acc <= '0;
          ci  <= ci + 4'd1;
          if (ci == 4'd15) begin
            det <= '0;
          end
        end
        S_DL: begin
          x <= CofWidth'(store_rdata);
          y <= cof_rdata;
        end
        S_DM:  prod <= mult[63:0];
        S_DACC: begin
          det <= det + 64'(rp);
          dk  <= dk + 4'd1;
        end
        S_CHK: dk <= '0;
        S_QL:  qneg <= cof_rdata[CofWidth-1] ^ det[63];
        S_QOUT: if (out_free) dk <= dk + 4'd1;
        default: ;
      endcase
    end
  end

  icu_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({cof_mag[31:0], 16'd0}),
    .den   (det_mag),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule
